>>> rtl/sacl_pkg.sv
package sacl_pkg;

  localparam logic [2:0] KIND_LOOKUP  = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_WRITE   = 3'd2;
  localparam logic [2:0] KIND_INSTALL = 3'd3;
  localparam logic [2:0] KIND_SNOOP   = 3'd4;
  localparam logic [2:0] KIND_REBUILD = 3'd5;

  localparam logic [1:0] LINE_INVALID  = 2'd0;
  localparam logic [1:0] LINE_MODIFIED = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] address;
    logic [1:0]  way;
    logic [1:0]  new_state;
    logic        snoop_in;
    logic [3:0]  access_size;
    logic [63:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  hit_way;
    logic        free_found;
    logic [1:0]  free_way;
    logic [1:0]  victim_way;
    logic [1:0]  line_state;
    logic        snoop_bit;
    logic [63:0] read_data;
    logic [47:0] rebuilt_address;
    logic        address_valid;
  } out_item_t;

endpackage

>>> rtl/sacl_in_if.sv
interface sacl_in_if;
  import sacl_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/sacl_out_if.sv
interface sacl_out_if;
  import sacl_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/set_assoc_cache_lru_stamps.sv
// set-associative cache store with timestamp lru
// in_i carries one request item (lookup, read, write, install, snoop, rebuild),
// out_o returns exactly one result item per request, in order
// every result carries the lookup of the addressed set taken before the update
// an item first reads the set row and data words from the synchronous
// memories, then modifies, writes back and loads the output register
// one item is in flight at a time, so no new item is taken until the last
// one has been written back
// after reset the block sweeps the set row memory, one set per cycle, and
// accepts no item until the sweep ends
// line data is not cleared; bytes never written read as anything
// if the receiver stalls, the result waits in the output register and the
// next item is read but held before write-back until the register frees
module set_assoc_cache_lru_stamps #(
  parameter int WAYS        = 4,
  parameter int SETS        = 64,
  parameter int BLOCK_BYTES = 64,
  parameter int ADDR_BITS   = 48,
  parameter int STAMP_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sacl_in_if.sink    in_i,
  sacl_out_if.source out_o
);
  import sacl_pkg::*;

  localparam int OB     = $clog2(BLOCK_BYTES);
  localparam int SB     = $clog2(SETS);
  localparam int SH     = OB + SB;
  localparam int SET_W  = (SB > 0) ? SB : 1;
  localparam int WAY_W  = ($clog2(WAYS) > 0) ? $clog2(WAYS) : 1;
  localparam int WP     = 2 ** $clog2(WAYS);
  localparam int TAG_W  = (ADDR_BITS > SH) ? ADDR_BITS - SH : 1;
  localparam int ENT_W  = TAG_W + 3 + STAMP_BITS;
  localparam int ROW_W  = WAYS * ENT_W + STAMP_BITS;
  localparam int LINES  = WAYS * SETS;
  localparam int RPL    = (BLOCK_BYTES + 15) / 16;
  localparam int EXTRA  = (2 ** OB + 15) / 16 + 1;
  localparam int DEPTH  = LINES * RPL + EXTRA;
  localparam int BA_W   = $clog2(DEPTH);
  localparam int K_W    = (OB > 3) ? OB - 3 : 1;
  localparam int P_W    = OB + 2;
  localparam logic [63:0] AMASK = (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [SET_W-1:0] SMASK = SET_W'((1 << SB) - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [SET_W-1:0] clr_q;

  logic [ROW_W-1:0] meta_mem [SETS];
  logic [63:0]      even_mem [DEPTH];
  logic [63:0]      odd_mem  [DEPTH];

  logic [ROW_W-1:0] row_q;
  logic [63:0]      even_rd_q, odd_rd_q;

  logic [2:0]       kind_q;
  logic [SET_W-1:0] set_q;
  logic [WAY_W-1:0] way_q;
  logic [TAG_W-1:0] tag_q;
  logic [OB-1:0]    off_q;
  logic [1:0]       nstate_q;
  logic             snoop_q;
  logic [3:0]       size_q;
  logic [63:0]      wdata_q;
  logic [BA_W-1:0]  ev_a_q, od_a_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic accept, finish;
  assign in_i.ready  = (state_q == S_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign finish      = (state_q == S_EXEC) && (!out_valid_q || out_o.ready);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // request decode
  logic [63:0]      a_full;
  logic [SET_W-1:0] set_raw, set_m;
  logic [2:0]       way_x;
  logic [OB-1:0]    off_m;
  logic [K_W-1:0]   k_m;
  logic [BA_W-1:0]  base_a, row_a;
  logic [3:0]       size_m;

  always_comb begin
    a_full  = {16'd0, in_i.data.address} & AMASK;
    set_raw = SET_W'(a_full >> OB) & SMASK;
    if ({1'b0, set_raw} >= (SET_W + 1)'(SETS)) begin
      set_m = SET_W'({1'b0, set_raw} - (SET_W + 1)'(SETS));
    end else begin
      set_m = set_raw;
    end
    way_x = {1'b0, in_i.data.way};
    for (int i = 0; i < 3; i++) begin
      if ({2'b0, way_x} >= 5'(WAYS)) begin
        way_x = 3'({2'b0, way_x} - 5'(WAYS));
      end
    end
    off_m  = a_full[OB-1:0];
    k_m    = K_W'({1'b0, off_m} >> 3);
    base_a = BA_W'((int'(set_m) * WAYS + int'(way_x)) * RPL);
    row_a  = BA_W'(base_a + BA_W'(k_m >> 1));
    size_m = (in_i.data.access_size > 4'd8) ? 4'd8 : in_i.data.access_size;
  end

  // row unpack and lookup
  logic [TAG_W-1:0]      tg   [WAYS];
  logic [1:0]            st   [WAYS];
  logic                  sn   [WAYS];
  logic [STAMP_BITS-1:0] stp  [WAYS];
  logic [STAMP_BITS-1:0] cnt;
  logic                  hit, free_found;
  logic [WAY_W-1:0]      hit_way, free_way;
  logic [STAMP_BITS-1:0] nd_s [2*WP-1];
  logic [WAY_W-1:0]      nd_i [2*WP-1];
  logic                  nd_v [2*WP-1];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tg[w]  = row_q[w*ENT_W +: TAG_W];
      st[w]  = row_q[w*ENT_W + TAG_W +: 2];
      sn[w]  = row_q[w*ENT_W + TAG_W + 2];
      stp[w] = row_q[w*ENT_W + TAG_W + 3 +: STAMP_BITS];
    end
    cnt        = row_q[WAYS*ENT_W +: STAMP_BITS];
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && st[w] != LINE_INVALID && tg[w] == tag_q) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free_found && st[w] == LINE_INVALID) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
    for (int n = 0; n < 2*WP-1; n++) begin
      nd_s[n] = '0;
      nd_i[n] = '0;
      nd_v[n] = 1'b0;
    end
    for (int w = 0; w < WP; w++) begin
      if (w < WAYS) begin
        nd_s[WP-1+w] = stp[w];
        nd_i[WP-1+w] = WAY_W'(w);
        nd_v[WP-1+w] = 1'b1;
      end
    end
    for (int n = WP - 2; n >= 0; n--) begin
      if (nd_v[2*n+1] && (!nd_v[2*n+2] || nd_s[2*n+1] <= nd_s[2*n+2])) begin
        nd_s[n] = nd_s[2*n+1];
        nd_i[n] = nd_i[2*n+1];
        nd_v[n] = nd_v[2*n+1];
      end else begin
        nd_s[n] = nd_s[2*n+2];
        nd_i[n] = nd_i[2*n+2];
        nd_v[n] = nd_v[2*n+2];
      end
    end
  end

  // update and result
  logic [ROW_W-1:0] row_new;
  logic [1:0]       st_new;
  logic             sn_new;
  logic [TAG_W-1:0] tg_new;
  logic [STAMP_BITS-1:0] stp_new, cnt_new;
  logic             kodd;
  logic [2:0]       bsel;
  logic [127:0]     rwin, wwin;
  logic [15:0]      wen;
  logic [63:0]      rdata;
  logic [63:0]      rb;
  logic             avalid;
  logic             mv;
  logic [7:0]       ev_we, od_we;
  logic [63:0]      ev_wd, od_wd;

  always_comb begin
    st_new  = st[way_q];
    sn_new  = sn[way_q];
    tg_new  = tg[way_q];
    stp_new = stp[way_q];
    cnt_new = cnt;
    avalid  = 1'b0;
    rb      = '0;
    case (kind_q)
      KIND_READ, KIND_WRITE: begin
        if (kind_q == KIND_WRITE) begin
          st_new = LINE_MODIFIED;
        end
        stp_new = cnt;
        cnt_new = cnt + 1'b1;
      end
      KIND_INSTALL: begin
        if (nstate_q != LINE_INVALID) begin
          stp_new = cnt;
          cnt_new = cnt + 1'b1;
        end
        tg_new = tag_q;
        st_new = nstate_q;
      end
      KIND_SNOOP: sn_new = snoop_q;
      KIND_REBUILD: begin
        if (st[way_q] != LINE_INVALID) begin
          avalid = 1'b1;
          rb = ((64'(tg[way_q]) << SH) | (64'(set_q) << OB)) & AMASK;
        end
      end
      default: ;
    endcase
    row_new = row_q;
    row_new[way_q*ENT_W +: ENT_W] = {stp_new, sn_new, st_new, tg_new};
    row_new[WAYS*ENT_W +: STAMP_BITS] = cnt_new;

    kodd  = off_q[3 % OB] & (OB > 3);
    bsel  = off_q[2:0];
    rwin  = (kodd ? {even_rd_q, odd_rd_q} : {odd_rd_q, even_rd_q}) >> {bsel, 3'b000};
    wwin  = {64'd0, wdata_q} << {bsel, 3'b000};
    wen   = '0;
    rdata = '0;
    for (int i = 0; i < 8; i++) begin
      mv = (4'(i) < size_q) && ((P_W'(off_q) + P_W'(i)) < P_W'(BLOCK_BYTES));
      if (mv) begin
        wen[{1'b0, bsel} + 4'(i)] = 1'b1;
        if (kind_q == KIND_READ) begin
          rdata[8*i +: 8] = rwin[8*i +: 8];
        end
      end
    end
    ev_we = kodd ? wen[15:8] : wen[7:0];
    od_we = kodd ? wen[7:0] : wen[15:8];
    ev_wd = kodd ? wwin[127:64] : wwin[63:0];
    od_wd = kodd ? wwin[63:0] : wwin[127:64];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == SET_W'(SETS - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (finish) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= in_i.data.kind;
      set_q    <= set_m;
      way_q    <= WAY_W'(way_x);
      tag_q    <= TAG_W'(a_full >> SH);
      off_q    <= off_m;
      nstate_q <= in_i.data.new_state;
      snoop_q  <= in_i.data.snoop_in;
      size_q   <= size_m;
      wdata_q  <= in_i.data.write_data;
      ev_a_q   <= row_a + BA_W'(k_m[0] & (OB > 3));
      od_a_q   <= row_a;
    end
    if (finish) begin
      out_q.hit             <= hit;
      out_q.hit_way         <= 2'(hit_way);
      out_q.free_found      <= free_found;
      out_q.free_way        <= 2'(free_way);
      out_q.victim_way      <= 2'(nd_i[0]);
      out_q.line_state      <= st_new;
      out_q.snoop_bit       <= sn_new;
      out_q.read_data       <= rdata;
      out_q.rebuilt_address <= rb[47:0];
      out_q.address_valid   <= avalid;
    end
  end

  // set row memory
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      meta_mem[clr_q] <= '0;
    end else if (finish) begin
      meta_mem[set_q] <= row_new;
    end
    if (accept) begin
      row_q <= meta_mem[set_m];
    end
  end

  // line data, even and odd word banks
  always_ff @(posedge clk_i) begin
    if (finish && kind_q == KIND_WRITE) begin
      for (int j = 0; j < 8; j++) begin
        if (ev_we[j]) even_mem[ev_a_q][8*j +: 8] <= ev_wd[8*j +: 8];
        if (od_we[j]) odd_mem[od_a_q][8*j +: 8] <= od_wd[8*j +: 8];
      end
    end
    if (accept) begin
      even_rd_q <= even_mem[row_a + BA_W'(k_m[0] & (OB > 3))];
      odd_rd_q  <= odd_mem[row_a];
    end
  end

  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_i.ready) else $error("item accepted during clear");
  a_accept_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC) else $error("accepted item not executed");
  a_finish_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q) else $error("result lost");
  a_rebuild_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.address_valid |-> out_q.rebuilt_address == 48'd0)
    else $error("rebuilt address without valid line");

endmodule

>>> bench/set_assoc_cache_lru_stamps_tb.sv
module set_assoc_cache_lru_stamps_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sacl_pkg::*;

  localparam int NWAYS = 4;
  localparam int NSETS = 64;
  localparam int BLK   = 64;
  localparam int OB    = 6;
  localparam int SB    = 6;
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  typedef struct {
    in_item_t  item;
    bit        fixed;
    out_item_t result;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sacl_in_if  in_if();
  sacl_out_if out_if();

  set_assoc_cache_lru_stamps dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [35:0] tag_q   [NWAYS*NSETS];
  logic [1:0]  state_q [NWAYS*NSETS];
  logic        snoop_q [NWAYS*NSETS];
  logic [31:0] stamp_q [NWAYS*NSETS];
  logic [31:0] count_q [NSETS];
  logic [7:0]  bytes_q [NWAYS*NSETS*BLK];
  bit          known_q [NWAYS*NSETS*BLK];

  out_item_t pending_results[$];
  dir_row_t  dir_rows[$];
  logic [35:0] tag_pool[4];
  int idle_in, idle_out;
  int errors, results_seen, hits_seen, kind_count[8];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("== FAIL ==");
    $finish;
  end

  function automatic out_item_t cache_predict(in_item_t it);
    out_item_t r;
    logic [5:0]  off;
    logic [5:0]  set;
    logic [35:0] tag;
    int base, line, n, pos;
    logic [31:0] best;
    r = '0;
    off = it.address[OB-1:0];
    set = it.address[OB+SB-1:OB];
    tag = it.address[47:OB+SB];
    base = set * NWAYS;
    line = base + it.way;
    n = (it.access_size > 8) ? 8 : it.access_size;
    best = stamp_q[base];
    for (int w = 0; w < NWAYS; w++) begin
      if (!r.hit && state_q[base+w] != LINE_INVALID && tag_q[base+w] == tag) begin
        r.hit = 1'b1;
        r.hit_way = 2'(w);
      end
      if (!r.free_found && state_q[base+w] == LINE_INVALID) begin
        r.free_found = 1'b1;
        r.free_way = 2'(w);
      end
      if (stamp_q[base+w] < best) begin
        best = stamp_q[base+w];
        r.victim_way = 2'(w);
      end
    end
    case (it.kind)
      KIND_READ, KIND_WRITE: begin
        for (int i = 0; i < n; i++) begin
          pos = off + i;
          if (pos < BLK) begin
            if (it.kind == KIND_READ) begin
              r.read_data[8*i +: 8] = bytes_q[line*BLK+pos];
            end else begin
              bytes_q[line*BLK+pos] = it.write_data[8*i +: 8];
              known_q[line*BLK+pos] = 1'b1;
            end
          end
        end
        if (it.kind == KIND_WRITE) state_q[line] = LINE_MODIFIED;
        stamp_q[line] = count_q[set];
        count_q[set] = count_q[set] + 32'd1;
      end
      KIND_INSTALL: begin
        if (it.new_state != LINE_INVALID) begin
          stamp_q[line] = count_q[set];
          count_q[set] = count_q[set] + 32'd1;
        end
        tag_q[line] = tag;
        state_q[line] = it.new_state;
      end
      KIND_SNOOP: snoop_q[line] = it.snoop_in;
      KIND_REBUILD: begin
        if (state_q[line] != LINE_INVALID) begin
          r.address_valid = 1'b1;
          r.rebuilt_address = {tag_q[line], set, 6'd0};
        end
      end
      default: ;
    endcase
    r.line_state = state_q[line];
    r.snoop_bit = snoop_q[line];
    return r;
  endfunction

  // shrink a read so it only covers bytes already written
  function automatic logic [3:0] safe_read_size(in_item_t it);
    int n, pos, line;
    n = (it.access_size > 8) ? 8 : it.access_size;
    line = it.address[OB+SB-1:OB] * NWAYS + it.way;
    for (int i = 0; i < n; i++) begin
      pos = it.address[OB-1:0] + i;
      if (pos >= BLK) return it.access_size;
      if (!known_q[line*BLK+pos]) return 4'(i);
    end
    return it.access_size;
  endfunction

  function automatic in_item_t mk(logic [2:0] k, logic [47:0] a, logic [1:0] w,
                                  logic [1:0] s, logic sn, logic [3:0] sz,
                                  logic [63:0] wd);
    in_item_t it;
    it.kind = k;
    it.address = a;
    it.way = w;
    it.new_state = s;
    it.snoop_in = sn;
    it.access_size = sz;
    it.write_data = wd;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it.address = 48'({$urandom, $urandom});
    it.way = 2'($urandom);
    it.new_state = 2'($urandom);
    it.snoop_in = 1'($urandom);
    it.access_size = 4'($urandom);
    it.write_data = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 10) it.kind = KIND_LOOKUP;
    else if (pick < 35) it.kind = KIND_READ;
    else if (pick < 60) it.kind = KIND_WRITE;
    else if (pick < 80) it.kind = KIND_INSTALL;
    else if (pick < 88) it.kind = KIND_SNOOP;
    else if (pick < 96) it.kind = KIND_REBUILD;
    else it.kind = 3'($urandom_range(KIND_SPARE6, KIND_SPARE7));
    if ($urandom_range(0, 99) < 85) begin
      it.address[47:12] = tag_pool[$urandom_range(0, 3)];
      case ($urandom_range(0, 3))
        0: it.address[11:6] = 6'd0;
        1: it.address[11:6] = 6'd1;
        2: it.address[11:6] = 6'd63;
        default: it.address[11:6] = 6'($urandom_range(0, 7));
      endcase
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit fixed, out_item_t fixed_res);
    out_item_t r;
    if (it.kind == KIND_READ) it.access_size = safe_read_size(it);
    while ($urandom_range(0, 99) < idle_in) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data = it;
    do @(posedge clk); while (!in_if.ready);
    r = cache_predict(it);
    pending_results.push_back(fixed ? fixed_res : r);
    kind_count[it.kind]++;
    @(negedge clk);
  endtask

  task automatic cmp_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    out_if.ready <= rst_n ? ($urandom_range(0, 99) >= idle_out) : 1'b0;
  end

  always @(posedge clk) begin
    out_item_t e, a;
    if (rst_n && out_if.valid && out_if.ready) begin
      a = out_if.data;
      results_seen++;
      if (a.hit) hits_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, a);
        errors++;
      end else begin
        e = pending_results.pop_front();
        cmp_field("hit", e.hit, a.hit);
        cmp_field("hit_way", e.hit_way, a.hit_way);
        cmp_field("free_found", e.free_found, a.free_found);
        cmp_field("free_way", e.free_way, a.free_way);
        cmp_field("victim_way", e.victim_way, a.victim_way);
        cmp_field("line_state", e.line_state, a.line_state);
        cmp_field("snoop_bit", e.snoop_bit, a.snoop_bit);
        cmp_field("read_data", e.read_data, a.read_data);
        cmp_field("rebuilt_address", e.rebuilt_address, a.rebuilt_address);
        cmp_field("address_valid", e.address_valid, a.address_valid);
      end
    end
  end

  initial begin
    dir_row_t row;
    out_item_t empty_set;
    logic [47:0] a;
    int wait_cycles;
    in_if.valid = 1'b0;
    in_if.data = '0;
    rst_n = 1'b0;
    errors = 0;
    results_seen = 0;
    hits_seen = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
    foreach (tag_q[i]) begin
      tag_q[i] = '0;
      state_q[i] = LINE_INVALID;
      snoop_q[i] = 1'b0;
      stamp_q[i] = '0;
    end
    foreach (count_q[i]) count_q[i] = '0;
    foreach (bytes_q[i]) begin
      bytes_q[i] = '0;
      known_q[i] = 1'b0;
    end
    foreach (tag_pool[i]) tag_pool[i] = 36'({$urandom, $urandom});
    tag_pool[0] = '1;

    empty_set = '0;
    empty_set.free_found = 1'b1;
    a = 48'h0000_1234_5abc;
    row.fixed = 1'b1;
    row.result = empty_set;
    row.item = mk(KIND_LOOKUP, '0, 2'd0, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_REBUILD, '0, 2'd0, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_LOOKUP, '1, 2'd3, 2'd3, 1'b1, 4'd15, '1);
    dir_rows.push_back(row);
    row.fixed = 1'b0;
    row.item = mk(KIND_INSTALL, a, 2'd2, 2'd1, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_LOOKUP, a, 2'd0, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_WRITE, a | 48'h3c, 2'd2, 2'd0, 1'b0, 4'd8, 64'h0123_4567_89ab_cdef);
    dir_rows.push_back(row);
    row.item = mk(KIND_READ, a | 48'h3c, 2'd2, 2'd0, 1'b0, 4'd15, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_WRITE, a, 2'd3, 2'd0, 1'b0, 4'd12, '1);
    dir_rows.push_back(row);
    row.item = mk(KIND_READ, a, 2'd3, 2'd0, 1'b0, 4'd8, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_READ, a, 2'd3, 2'd0, 1'b0, 4'd0, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_WRITE, a, 2'd1, 2'd0, 1'b0, 4'd0, '1);
    dir_rows.push_back(row);
    row.item = mk(KIND_SNOOP, a, 2'd2, 2'd0, 1'b1, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_REBUILD, a, 2'd2, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_INSTALL, '1, 2'd3, 2'd3, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_REBUILD, '1, 2'd3, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_LOOKUP, '1, 2'd0, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_INSTALL, a, 2'd2, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_REBUILD, a, 2'd2, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_INSTALL, a, 2'd0, 2'd2, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_SNOOP, a, 2'd2, 2'd0, 1'b0, 4'd1, '0);
    dir_rows.push_back(row);
    row.item = mk(KIND_SPARE6, a, 2'd0, 2'd3, 1'b1, 4'd8, '1);
    dir_rows.push_back(row);
    row.item = mk(KIND_SPARE7, a, 2'd3, 2'd3, 1'b1, 4'd8, '1);
    dir_rows.push_back(row);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idle_in = 36;
    idle_out = 79;
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].result);
    for (int ph = 0; ph < 3; ph++) begin
      idle_in = (ph == 0) ? 36 : (ph == 1) ? 79 : 0;
      idle_out = (ph == 0) ? 79 : (ph == 1) ? 36 : 0;
      repeat (317) send_item(random_item(), 1'b0, empty_set);
    end
    in_if.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 20) begin
      @(posedge clk);
      wait_cycles++;
    end
    $display("items: %0d lookup, %0d read, %0d write, %0d install, %0d snoop, %0d rebuild",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
             kind_count[5]);
    $display("results checked: %0d, hits among them: %0d, errors: %0d",
             results_seen, hits_seen, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
